[rtl/core/lcab_pkg.sv]
// Package for the binary-lifting lowest-common-ancestor block.
// Holds command, status and kind codes, field widths and the result struct.
// No dependencies.
package lcab_pkg;

    localparam int DEF_MAX_NODES = 1024;
    localparam int DEF_LEVELS    = 10;
    localparam int NODE_FIELD_W  = 10;
    localparam int CFG_W         = 11;
    localparam int CMD_W         = 2;
    localparam int STATUS_W      = 2;

    localparam logic [CMD_W-1:0] CMD_LOAD  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_BUILD = 2'd1;
    localparam logic [CMD_W-1:0] CMD_QUERY = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_RANGE     = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NOT_BUILT = 2'd2;

    localparam logic KIND_BUILD = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    typedef struct packed {
        logic                    valid;
        logic                    kind;
        logic [NODE_FIELD_W-1:0] ancestor;
        logic [STATUS_W-1:0]     status;
    } lcab_res_t;

endpackage

[rtl/core/lcab_ram.sv]
// Simple dual-port memory with one write port and one registered read port.
// No dependencies.
module lcab_ram #(
    parameter int DEPTH  = 1024,
    parameter int DATA_W = 10,
    parameter int ADDR_W = 10
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        rdata <= mem[raddr];
    end

endmodule

[rtl/core/lcab_seq.sv]
// Sequencer that loads parents, builds the ancestor and depth tables and
// answers queries. Uses lcab_pkg.
module lcab_seq import lcab_pkg::*; #(
    parameter int MAX_NODES = DEF_MAX_NODES,
    parameter int LEVELS    = DEF_LEVELS,
    parameter int NODE_W    = 10,
    parameter int ENT_W     = 11,
    parameter int LW        = 4,
    parameter int DEP_W     = 10
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    start,
    input  logic [CMD_W-1:0]        cmd,
    input  logic [NODE_FIELD_W-1:0] node_a,
    input  logic [NODE_FIELD_W-1:0] node_b,
    input  logic [ENT_W-1:0]        n,
    input  logic                    cfg_clear,
    output logic                    idle,
    output lcab_res_t               res,
    output logic                    jt_we,
    output logic [LW+NODE_W-1:0]    jt_waddr,
    output logic [ENT_W-1:0]        jt_wdata,
    output logic [LW+NODE_W-1:0]    jt_raddr,
    input  logic [ENT_W-1:0]        jt_rdata,
    output logic                    dp_we,
    output logic [NODE_W-1:0]       dp_waddr,
    output logic [DEP_W-1:0]        dp_wdata,
    output logic [NODE_W-1:0]       dp_raddr,
    input  logic [DEP_W-1:0]        dp_rdata
);

    localparam int SW  = 5;
    localparam int CW  = (ENT_W > NODE_FIELD_W) ? ENT_W : NODE_FIELD_W + 1;
    localparam logic [ENT_W-1:0] NONE = ENT_W'(MAX_NODES);
    localparam logic [LW-1:0]    JTOP = LW'(LEVELS - 1);

    localparam logic [SW-1:0] S_IDLE = 5'd0;
    localparam logic [SW-1:0] S_B1R  = 5'd1;
    localparam logic [SW-1:0] S_B1W  = 5'd2;
    localparam logic [SW-1:0] S_B2R  = 5'd3;
    localparam logic [SW-1:0] S_B2M  = 5'd4;
    localparam logic [SW-1:0] S_B2W  = 5'd5;
    localparam logic [SW-1:0] S_B3R  = 5'd6;
    localparam logic [SW-1:0] S_B3U  = 5'd7;
    localparam logic [SW-1:0] S_QDA  = 5'd8;
    localparam logic [SW-1:0] S_QDB  = 5'd9;
    localparam logic [SW-1:0] S_QL1  = 5'd10;
    localparam logic [SW-1:0] S_QL1U = 5'd11;
    localparam logic [SW-1:0] S_QCHK = 5'd12;
    localparam logic [SW-1:0] S_QL2A = 5'd13;
    localparam logic [SW-1:0] S_QL2B = 5'd14;
    localparam logic [SW-1:0] S_QL2C = 5'd15;
    localparam logic [SW-1:0] S_QF   = 5'd16;
    localparam logic [SW-1:0] S_QFU  = 5'd17;

    logic [SW-1:0]     state_reg, state_next;
    logic [ENT_W-1:0]  i_reg, i_next;
    logic [LW-1:0]     j_reg, j_next;
    logic [NODE_W-1:0] a_reg, a_next, b_reg, b_next;
    logic [DEP_W-1:0]  da_reg, da_next, db_reg, db_next, d_reg, d_next;
    logic [ENT_W-1:0]  ua_reg, ua_next;
    logic              built_reg, built_next;

    logic [ENT_W-1:0]  i_inc;
    logic [DEP_W:0]    step;
    logic [DEP_W-1:0]  d_add;
    logic              q_in;
    logic              a_bad, b_bad;

    assign i_inc = i_reg + ENT_W'(1);
    assign step  = (DEP_W+1)'(1) << j_reg;
    assign d_add = d_reg | step[DEP_W-1:0];
    assign q_in  = jt_rdata < n;
    assign a_bad = CW'(node_a) >= CW'(n);
    assign b_bad = CW'(node_b) >= CW'(n);
    assign idle  = state_reg == S_IDLE;

    always_comb begin
        state_next = state_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        a_next     = a_reg;
        b_next     = b_reg;
        da_next    = da_reg;
        db_next    = db_reg;
        d_next     = d_reg;
        ua_next    = ua_reg;
        built_next = built_reg;
        res        = '0;
        jt_we      = 1'b0;
        jt_waddr   = '0;
        jt_wdata   = '0;
        jt_raddr   = '0;
        dp_we      = 1'b0;
        dp_waddr   = '0;
        dp_wdata   = '0;
        dp_raddr   = '0;
        case (state_reg)
            S_IDLE: begin
                if (start) begin
                    case (cmd)
                        CMD_LOAD: begin
                            built_next = 1'b0;
                            if (node_a != '0 && !a_bad && !b_bad) begin
                                jt_we    = 1'b1;
                                jt_waddr = {LW'(0), NODE_W'(node_a)};
                                jt_wdata = ENT_W'(node_b);
                            end
                        end
                        CMD_BUILD: begin
                            i_next     = '0;
                            state_next = S_B1R;
                        end
                        CMD_QUERY: begin
                            res.valid = a_bad || b_bad || !built_reg;
                            res.kind  = KIND_QUERY;
                            if (a_bad || b_bad) begin
                                res.status = ST_RANGE;
                            end else if (!built_reg) begin
                                res.status = ST_NOT_BUILT;
                            end else begin
                                a_next     = NODE_W'(node_a);
                                b_next     = NODE_W'(node_b);
                                dp_raddr   = NODE_W'(node_a);
                                state_next = S_QDA;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_B1R: begin
                jt_raddr   = {LW'(0), i_reg[NODE_W-1:0]};
                state_next = S_B1W;
            end
            S_B1W: begin
                jt_waddr = {LW'(0), i_reg[NODE_W-1:0]};
                if (i_reg == '0) begin
                    jt_we    = 1'b1;
                    jt_wdata = NONE;
                end else if (!q_in) begin
                    jt_we    = 1'b1;
                    jt_wdata = '0;
                end
                i_next     = i_inc;
                state_next = S_B1R;
                if (i_inc == n) begin
                    i_next = '0;
                    if (LEVELS > 1) begin
                        j_next     = LW'(1);
                        state_next = S_B2R;
                    end else begin
                        j_next     = JTOP;
                        a_next     = '0;
                        d_next     = '0;
                        state_next = S_B3R;
                    end
                end
            end
            S_B2R: begin
                jt_raddr   = {j_reg - LW'(1), i_reg[NODE_W-1:0]};
                state_next = S_B2M;
            end
            S_B2M, S_B2W: begin
                if (state_reg == S_B2M && q_in) begin
                    jt_raddr   = {j_reg - LW'(1), jt_rdata[NODE_W-1:0]};
                    state_next = S_B2W;
                end else begin
                    jt_we      = 1'b1;
                    jt_waddr   = {j_reg, i_reg[NODE_W-1:0]};
                    jt_wdata   = (state_reg == S_B2M) ? NONE : jt_rdata;
                    i_next     = i_inc;
                    state_next = S_B2R;
                    if (i_inc == n) begin
                        i_next = '0;
                        if (j_reg == JTOP) begin
                            a_next     = '0;
                            d_next     = '0;
                            state_next = S_B3R;
                        end else begin
                            j_next = j_reg + LW'(1);
                        end
                    end
                end
            end
            S_B3R: begin
                jt_raddr   = {j_reg, a_reg};
                state_next = S_B3U;
            end
            S_B3U: begin
                if (q_in) begin
                    a_next = jt_rdata[NODE_W-1:0];
                    d_next = d_add;
                end
                j_next     = j_reg - LW'(1);
                state_next = S_B3R;
                if (j_reg == '0) begin
                    dp_we    = 1'b1;
                    dp_waddr = i_reg[NODE_W-1:0];
                    dp_wdata = q_in ? d_add : d_reg;
                    i_next   = i_inc;
                    a_next   = i_inc[NODE_W-1:0];
                    d_next   = '0;
                    j_next   = JTOP;
                    if (i_inc == n) begin
                        built_next = 1'b1;
                        res.valid  = 1'b1;
                        res.kind   = KIND_BUILD;
                        res.status = ST_OK;
                        state_next = S_IDLE;
                    end
                end
            end
            S_QDA: begin
                da_next    = dp_rdata;
                dp_raddr   = b_reg;
                state_next = S_QDB;
            end
            S_QDB: begin
                j_next = JTOP;
                if (da_reg < dp_rdata) begin
                    a_next  = b_reg;
                    b_next  = a_reg;
                    da_next = dp_rdata;
                    db_next = da_reg;
                end else begin
                    db_next = dp_rdata;
                end
                state_next = S_QL1;
            end
            S_QL1: begin
                if ((DEP_W+1)'(da_reg) >= (DEP_W+1)'(db_reg) + step) begin
                    jt_raddr   = {j_reg, a_reg};
                    state_next = S_QL1U;
                end else if (j_reg == '0) begin
                    state_next = S_QCHK;
                end else begin
                    j_next = j_reg - LW'(1);
                end
            end
            S_QL1U: begin
                if (q_in) begin
                    a_next  = jt_rdata[NODE_W-1:0];
                    da_next = da_reg - step[DEP_W-1:0];
                end
                j_next     = j_reg - LW'(1);
                state_next = (j_reg == '0) ? S_QCHK : S_QL1;
            end
            S_QCHK: begin
                if (a_reg == b_reg) begin
                    res.valid    = 1'b1;
                    res.kind     = KIND_QUERY;
                    res.ancestor = NODE_FIELD_W'(a_reg);
                    res.status   = ST_OK;
                    state_next   = S_IDLE;
                end else begin
                    j_next     = JTOP;
                    state_next = S_QL2A;
                end
            end
            S_QL2A: begin
                jt_raddr   = {j_reg, a_reg};
                state_next = S_QL2B;
            end
            S_QL2B: begin
                ua_next    = jt_rdata;
                jt_raddr   = {j_reg, b_reg};
                state_next = S_QL2C;
            end
            S_QL2C: begin
                if (ua_reg < n && q_in && ua_reg != jt_rdata) begin
                    a_next = ua_reg[NODE_W-1:0];
                    b_next = jt_rdata[NODE_W-1:0];
                end
                j_next     = j_reg - LW'(1);
                state_next = (j_reg == '0) ? S_QF : S_QL2A;
            end
            S_QF: begin
                jt_raddr   = {LW'(0), a_reg};
                state_next = S_QFU;
            end
            S_QFU: begin
                res.valid    = 1'b1;
                res.kind     = KIND_QUERY;
                res.ancestor = q_in ? NODE_FIELD_W'(jt_rdata) : '0;
                res.status   = ST_OK;
                state_next   = S_IDLE;
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
        if (cfg_clear) begin
            built_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            built_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            built_reg <= built_next;
        end
        i_reg  <= i_next;
        j_reg  <= j_next;
        a_reg  <= a_next;
        b_reg  <= b_next;
        da_reg <= da_next;
        db_reg <= db_next;
        d_reg  <= d_next;
        ua_reg <= ua_next;
    end

endmodule

[rtl/core/lca_binary_lifting.sv]
// Top level of the binary-lifting lowest-common-ancestor block.
// Uses lcab_pkg, lcab_seq and lcab_ram.
//
//   channel   direction  handshake         payload
//   s_        in         s_valid/s_ready   s_command, s_node_a, s_node_b
//   m_        out        m_valid/m_ready   m_kind, m_ancestor, m_status
//   cfg_      in         cfg_we            cfg_wdata (node_count)
//
// A load or a failed query is handled without leaving the idle state. A query that
// reaches the tables and a build go through the single read port of the ancestor table.
// Reset is synchronous and active low; it clears the built flag and sets
// node_count to its default. A new item is taken only while the sequencer is
// idle and no result waits in the output register.
module lca_binary_lifting import lcab_pkg::*; #(
    parameter int MAX_NODES = DEF_MAX_NODES,
    parameter int LEVELS    = DEF_LEVELS
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic [CMD_W-1:0]        s_command,
    input  logic [NODE_FIELD_W-1:0] s_node_a,
    input  logic [NODE_FIELD_W-1:0] s_node_b,
    output logic                    m_valid,
    input  logic                    m_ready,
    output logic                    m_kind,
    output logic [NODE_FIELD_W-1:0] m_ancestor,
    output logic [STATUS_W-1:0]     m_status,
    input  logic                    cfg_we,
    input  logic [CFG_W-1:0]        cfg_wdata
);

    localparam int NODE_W = (MAX_NODES > 2) ? $clog2(MAX_NODES) : 1;
    localparam int ENT_W  = NODE_W + 1;
    localparam int LW     = (LEVELS > 1) ? $clog2(LEVELS) : 1;
    localparam int DEP_W  = LEVELS;
    localparam int JT_DEPTH = LEVELS * (1 << NODE_W);
    localparam int W      = (ENT_W > CFG_W) ? ENT_W : CFG_W;
    localparam int RST_N  = (MAX_NODES < 1024) ? MAX_NODES : 1024;

    logic [ENT_W-1:0] n_reg, n_next;
    logic             m_valid_reg, m_valid_next;
    logic             kind_reg;
    logic [NODE_FIELD_W-1:0] anc_reg;
    logic [STATUS_W-1:0]     status_reg;

    logic              seq_idle;
    lcab_res_t         res;
    logic              jt_we;
    logic [LW+NODE_W-1:0] jt_waddr, jt_raddr;
    logic [ENT_W-1:0]  jt_wdata, jt_rdata;
    logic              dp_we;
    logic [NODE_W-1:0] dp_waddr, dp_raddr;
    logic [DEP_W-1:0]  dp_wdata, dp_rdata;

    assign s_ready    = seq_idle && !m_valid_reg;
    assign m_valid    = m_valid_reg;
    assign m_kind     = kind_reg;
    assign m_ancestor = anc_reg;
    assign m_status   = status_reg;

    always_comb begin
        n_next = n_reg;
        if (cfg_we) begin
            if (cfg_wdata == '0) begin
                n_next = ENT_W'(1);
            end else if (W'(cfg_wdata) > W'(MAX_NODES)) begin
                n_next = ENT_W'(MAX_NODES);
            end else begin
                n_next = ENT_W'(cfg_wdata);
            end
        end
        m_valid_next = m_valid_reg && !m_ready;
        if (res.valid) begin
            m_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            n_reg       <= ENT_W'(RST_N);
            m_valid_reg <= 1'b0;
        end else begin
            n_reg       <= n_next;
            m_valid_reg <= m_valid_next;
        end
        if (res.valid) begin
            kind_reg   <= res.kind;
            anc_reg    <= res.ancestor;
            status_reg <= res.status;
        end
    end

    lcab_seq #(
        .MAX_NODES(MAX_NODES),
        .LEVELS   (LEVELS),
        .NODE_W   (NODE_W),
        .ENT_W    (ENT_W),
        .LW       (LW),
        .DEP_W    (DEP_W)
    ) u_seq (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (s_valid && s_ready),
        .cmd      (s_command),
        .node_a   (s_node_a),
        .node_b   (s_node_b),
        .n        (n_reg),
        .cfg_clear(cfg_we),
        .idle     (seq_idle),
        .res      (res),
        .jt_we    (jt_we),
        .jt_waddr (jt_waddr),
        .jt_wdata (jt_wdata),
        .jt_raddr (jt_raddr),
        .jt_rdata (jt_rdata),
        .dp_we    (dp_we),
        .dp_waddr (dp_waddr),
        .dp_wdata (dp_wdata),
        .dp_raddr (dp_raddr),
        .dp_rdata (dp_rdata)
    );

    lcab_ram #(
        .DEPTH (JT_DEPTH),
        .DATA_W(ENT_W),
        .ADDR_W(LW + NODE_W)
    ) u_jump (
        .aclk (aclk),
        .we   (jt_we),
        .waddr(jt_waddr),
        .wdata(jt_wdata),
        .raddr(jt_raddr),
        .rdata(jt_rdata)
    );

    lcab_ram #(
        .DEPTH (1 << NODE_W),
        .DATA_W(DEP_W),
        .ADDR_W(NODE_W)
    ) u_depth (
        .aclk (aclk),
        .we   (dp_we),
        .waddr(dp_waddr),
        .wdata(dp_wdata),
        .raddr(dp_raddr),
        .rdata(dp_rdata)
    );

endmodule

[rtl/core/lcab_checker.sv]
// Port-level checks for lca_binary_lifting, attached by a bind statement.
// Uses lcab_pkg.
module lcab_checker import lcab_pkg::*; (
    input logic                    aclk,
    input logic                    aresetn,
    input logic                    s_ready,
    input logic                    m_valid,
    input logic                    m_ready,
    input logic                    m_kind,
    input logic [NODE_FIELD_W-1:0] m_ancestor,
    input logic [STATUS_W-1:0]     m_status
);

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_ancestor) && $stable(m_status))
        else $error("Result item changed while stalled.");

    a_build_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_kind == KIND_BUILD |-> m_ancestor == '0 && m_status == ST_OK)
        else $error("Build item carries an answer or an error.");

    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status != ST_OK |-> m_ancestor == '0 && m_kind == KIND_QUERY)
        else $error("Failed query carries a nonzero ancestor.");

    a_no_take: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !s_ready)
        else $error("Input taken while a result item waits.");

    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("Result valid after reset.");

endmodule

bind lca_binary_lifting lcab_checker u_lcab_checker (
    .aclk      (aclk),
    .aresetn   (aresetn),
    .s_ready   (s_ready),
    .m_valid   (m_valid),
    .m_ready   (m_ready),
    .m_kind    (m_kind),
    .m_ancestor(m_ancestor),
    .m_status  (m_status)
);

[dv/tb_top.sv]
// Self-checking testbench for the lca_binary_lifting block.
// Drives load, build and query items against a predictor of the ancestor tables.
// Depends on lcab_pkg and the lca_binary_lifting RTL.
module tb_top;
    import lcab_pkg::*;

    localparam int NODES    = DEF_MAX_NODES;
    localparam int LVLS     = DEF_LEVELS;
    localparam int NO_ANC   = NODES;
    localparam int IDLE_MAX = 200000;
    localparam logic [CMD_W-1:0] CMD_IGNORED = 2'd3;

    typedef struct {
        logic [CMD_W-1:0]        cmd;
        logic [NODE_FIELD_W-1:0] a;
        logic [NODE_FIELD_W-1:0] b;
    } lca_req_t;

    typedef struct {
        logic                    kind;
        logic [NODE_FIELD_W-1:0] ancestor;
        logic [STATUS_W-1:0]     status;
    } lca_ans_t;

    logic                    aclk = 1'b0;
    logic                    aresetn = 1'b0;
    logic                    s_valid = 1'b0;
    logic                    s_ready;
    logic [CMD_W-1:0]        s_command = CMD_LOAD;
    logic [NODE_FIELD_W-1:0] s_node_a = '0;
    logic [NODE_FIELD_W-1:0] s_node_b = '0;
    logic                    m_valid;
    logic                    m_ready = 1'b0;
    logic                    m_kind;
    logic [NODE_FIELD_W-1:0] m_ancestor;
    logic [STATUS_W-1:0]     m_status;
    logic                    cfg_we = 1'b0;
    logic [CFG_W-1:0]        cfg_wdata = '0;

    lca_req_t pending_reqs[$];
    lca_ans_t expected_answers[$];
    int       errors = 0;

    // Predictor state.
    int jump_up[NODES][LVLS];
    int depth_of[NODES];
    bit tables_ok;
    int nodes_used;

    // Generator view of the tree.
    bit loaded[NODES];
    int gen_nodes;

    bit s_taken = 1'b0;
    int burst_left = 0;
    int gap_left = 0;
    int rx_mode = 0;
    int rx_left = 0;
    int hold_left = 0;
    bit hold_req = 1'b0;
    int idle_cycles = 0;

    lca_binary_lifting uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_command(s_command), .s_node_a(s_node_a), .s_node_b(s_node_b),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_kind(m_kind), .m_ancestor(m_ancestor), .m_status(m_status),
        .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
    );

    always #5 aclk = ~aclk;

    function automatic void build_jumps();
        int n;
        int u;
        int d;
        int up;
        n = nodes_used;
        for (int i = 0; i < n; i++) begin
            if (i == 0) jump_up[i][0] = NO_ANC;
            else if (jump_up[i][0] >= n) jump_up[i][0] = 0;
        end
        for (int j = 1; j < LVLS; j++) begin
            for (int i = 0; i < n; i++) begin
                up = jump_up[i][j-1];
                jump_up[i][j] = (up >= n) ? NO_ANC : jump_up[up][j-1];
            end
        end
        for (int i = 0; i < n; i++) begin
            u = i;
            d = 0;
            for (int j = LVLS - 1; j >= 0; j--) begin
                up = jump_up[u][j];
                if (up < n) begin
                    u = up;
                    d += 1 << j;
                end
            end
            depth_of[i] = d;
        end
        tables_ok = 1'b1;
    endfunction

    function automatic int common_ancestor(int a, int b);
        int n;
        int t;
        int da;
        int db;
        int ua;
        int ub;
        n = nodes_used;
        if (depth_of[a] < depth_of[b]) begin
            t = a;
            a = b;
            b = t;
        end
        da = depth_of[a];
        db = depth_of[b];
        for (int j = LVLS - 1; j >= 0; j--) begin
            if (da >= db + (1 << j) && jump_up[a][j] < n) begin
                a = jump_up[a][j];
                da -= 1 << j;
            end
        end
        if (a == b) return a;
        for (int j = LVLS - 1; j >= 0; j--) begin
            ua = jump_up[a][j];
            ub = jump_up[b][j];
            if (ua < n && ub < n && ua != ub) begin
                a = ua;
                b = ub;
            end
        end
        t = jump_up[a][0];
        return (t < n) ? t : 0;
    endfunction

    function automatic void predict_item(lca_req_t r);
        lca_ans_t e;
        int a;
        int b;
        a = int'(r.a);
        b = int'(r.b);
        e.kind = KIND_QUERY;
        e.ancestor = '0;
        e.status = ST_OK;
        if (r.cmd == CMD_LOAD) begin
            tables_ok = 1'b0;
            if (a != 0 && a < nodes_used && b < nodes_used) jump_up[a][0] = b;
        end else if (r.cmd == CMD_BUILD) begin
            build_jumps();
            e.kind = KIND_BUILD;
            expected_answers = {expected_answers, e};
        end else if (r.cmd == CMD_QUERY) begin
            if (a >= nodes_used || b >= nodes_used) e.status = ST_RANGE;
            else if (!tables_ok) e.status = ST_NOT_BUILT;
            else e.ancestor = NODE_FIELD_W'(common_ancestor(a, b));
            expected_answers = {expected_answers, e};
        end
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch on %s: got %0d, expected %0d at %0t", what, got, want, $time);
        errors++;
    endtask

    // Input acceptance, result checking, configuration tracking and the watchdog.
    always @(posedge aclk) begin
        lca_ans_t e;
        lca_req_t r;
        s_taken = 1'b0;
        if (!aresetn) begin
            tables_ok = 1'b0;
            nodes_used = NODES;
        end else begin
            if (cfg_we) begin
                nodes_used = (cfg_wdata < 1) ? 1 :
                             (cfg_wdata > NODES) ? NODES : int'(cfg_wdata);
                tables_ok = 1'b0;
            end
            if (s_valid && s_ready) begin
                r.cmd = s_command;
                r.a = s_node_a;
                r.b = s_node_b;
                predict_item(r);
                s_taken = 1'b1;
            end
            if (m_valid && m_ready) begin
                if (expected_answers.size() == 0) begin
                    report_mismatch("result count", 1, 0);
                end else begin
                    e = expected_answers.pop_front();
                    if (m_kind !== e.kind)
                        report_mismatch("kind", int'(m_kind), int'(e.kind));
                    if (m_ancestor !== e.ancestor)
                        report_mismatch("ancestor", int'(m_ancestor), int'(e.ancestor));
                    if (m_status !== e.status)
                        report_mismatch("status", int'(m_status), int'(e.status));
                end
            end
            if (s_taken || (m_valid && m_ready)) idle_cycles = 0;
            else idle_cycles++;
            if (idle_cycles > IDLE_MAX) begin
                $display("[lca_binary_lifting] ERROR");
                $finish;
            end
        end
    end

    // Sender: bursts of random length separated by random gaps.
    always @(negedge aclk) begin
        lca_req_t r;
        if (aresetn && (!s_valid || s_taken)) begin
            if (burst_left == 0 && gap_left == 0) begin
                burst_left = $urandom_range(1, 16);
                gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
            end
            if (gap_left > 0) begin
                gap_left--;
                s_valid <= 1'b0;
            end else if (pending_reqs.size() > 0) begin
                r = pending_reqs.pop_front();
                burst_left--;
                s_valid <= 1'b1;
                s_command <= r.cmd;
                s_node_a <= r.a;
                s_node_b <= r.b;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Receiver: changing stall patterns plus an occasional long hold-off.
    always @(negedge aclk) begin
        if (hold_req) begin
            hold_req = 1'b0;
            hold_left = 400;
        end
        if (rx_left == 0) begin
            rx_mode = $urandom_range(0, 2);
            rx_left = $urandom_range(8, 64);
        end
        rx_left--;
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else if (rx_mode == 0) begin
            m_ready <= 1'b1;
        end else if (rx_mode == 1) begin
            m_ready <= 1'($urandom_range(0, 1));
        end else begin
            m_ready <= ($urandom_range(0, 4) == 0);
        end
    end

    task automatic add_item(logic [CMD_W-1:0] cmd, int a, int b);
        lca_req_t r;
        r.cmd = cmd;
        r.a = NODE_FIELD_W'(a);
        r.b = NODE_FIELD_W'(b);
        if (cmd == CMD_LOAD && a != 0 && a < gen_nodes && b < gen_nodes) loaded[a] = 1'b1;
        pending_reqs = {pending_reqs, r};
    endtask

    task automatic settle();
        while (pending_reqs.size() > 0 || s_valid || expected_answers.size() > 0)
            @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    task automatic write_count(int v);
        settle();
        @(negedge aclk);
        cfg_we <= 1'b1;
        cfg_wdata <= CFG_W'(v);
        @(negedge aclk);
        cfg_we <= 1'b0;
        gen_nodes = (v < 1) ? 1 : (v > NODES) ? NODES : v;
    endtask

    task automatic add_query(int n);
        int a;
        int b;
        a = $urandom_range(0, n - 1);
        b = $urandom_range(0, n - 1);
        if ($urandom_range(0, 9) == 0) a = $urandom_range(0, NODES - 1);
        if ($urandom_range(0, 9) == 0) b = $urandom_range(0, NODES - 1);
        add_item(CMD_QUERY, a, b);
    endtask

    // shape: 0 random tree, 1 long chains, 2 arbitrary parents.
    task automatic tree_phase(int shape, int queries);
        int n;
        int p;
        logic [CMD_W-1:0] c;
        n = gen_nodes;
        for (int i = 1; i < n; i++) begin
            if (!loaded[i] || $urandom_range(0, 9) != 0) begin
                if (shape == 1) p = ($urandom_range(0, 7) == 0) ? $urandom_range(0, i - 1) : i - 1;
                else if (shape == 2) p = $urandom_range(0, n - 1);
                else p = $urandom_range(0, i - 1);
                add_item(CMD_LOAD, i, p);
            end
            if ($urandom_range(0, 15) == 0) begin
                c = CMD_W'($urandom_range(0, 2));
                if (c == CMD_BUILD) c = CMD_IGNORED;
                add_item(c, $urandom_range(0, NODES - 1), $urandom_range(0, NODES - 1));
            end
        end
        if ($urandom_range(0, 3) == 0) add_query(n);
        add_item(CMD_BUILD, $urandom_range(0, NODES - 1), $urandom_range(0, NODES - 1));
        for (int q = 0; q < queries; q++) begin
            add_query(n);
            if ($urandom_range(0, 29) == 0) begin
                add_item(CMD_LOAD, $urandom_range(1, n - 1 > 0 ? n - 1 : 1), 0);
                add_query(n);
                add_item(CMD_BUILD, 0, 0);
            end
            if ($urandom_range(0, 39) == 0)
                add_item(CMD_IGNORED, $urandom_range(0, NODES - 1), q);
        end
    endtask

    initial begin
        for (int i = 0; i < NODES; i++) begin
            loaded[i] = 1'b0;
            depth_of[i] = 0;
            for (int j = 0; j < LVLS; j++) jump_up[i][j] = 0;
        end
        gen_nodes = NODES;
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        add_item(CMD_QUERY, 0, 1023);
        add_item(CMD_IGNORED, 1023, 1023);
        write_count(0);
        add_item(CMD_QUERY, 0, 0);
        add_item(CMD_BUILD, 1023, 1023);
        add_item(CMD_QUERY, 0, 0);
        add_item(CMD_QUERY, 0, 1);
        add_item(CMD_QUERY, 1023, 0);
        add_item(CMD_LOAD, 0, 0);
        add_item(CMD_QUERY, 0, 0);
        write_count(2047);
        add_item(CMD_QUERY, 5, 6);
        write_count(6);
        add_item(CMD_LOAD, 1, 0);
        add_item(CMD_LOAD, 2, 1);
        add_item(CMD_LOAD, 3, 1);
        add_item(CMD_LOAD, 4, 2);
        add_item(CMD_LOAD, 5, 4);
        add_item(CMD_LOAD, 0, 3);
        add_item(CMD_LOAD, 7, 1);
        add_item(CMD_LOAD, 3, 9);
        add_item(CMD_BUILD, 0, 0);
        add_item(CMD_QUERY, 5, 3);
        add_item(CMD_QUERY, 4, 5);
        add_item(CMD_QUERY, 5, 5);
        add_item(CMD_QUERY, 2, 3);
        add_item(CMD_QUERY, 6, 1);

        write_count(600);
        hold_req = 1'b1;
        tree_phase(1, 60);
        for (int ph = 0; ph < 6; ph++) begin
            write_count($urandom_range(0, 7) == 0 ? $urandom_range(1, 3) : $urandom_range(4, 48));
            if (ph == 3) hold_req = 1'b1;
            tree_phase($urandom_range(0, 2), $urandom_range(10, 30));
        end
        write_count(1);
        add_item(CMD_BUILD, 0, 0);
        add_item(CMD_QUERY, 0, 0);

        settle();
        if (errors == 0) begin
            $display("[lca_binary_lifting] OK");
        end else begin
            $display("[lca_binary_lifting] ERROR");
        end
        $finish;
    end
endmodule
